### rtl/core/tape_image_deframer_assert.svh
// Assertion macros for the tape image deframer RTL.
// Include inside a module body; needs a clock and an active-low reset.
`ifndef TAPE_IMAGE_DEFRAMER_ASSERT_SVH
`define TAPE_IMAGE_DEFRAMER_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define TID_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define TID_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tid_pkg.sv
// Shared types and constants for the tape image deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tid_pkg;

  // Tape image byte codes
  localparam logic [7:0] MARK_BYTE   = 8'hA5;
  localparam logic [7:0] QUOTE_BYTE  = 8'h22;
  localparam logic [7:0] TYPE_BASIC  = 8'h42;
  localparam logic [7:0] TYPE_BINARY = 8'h4D;

  // Jump targets in the interpreter ROM
  localparam logic [15:0] PC_BASIC  = 16'h0CC1;
  localparam logic [15:0] PC_PROMPT = 16'h0CFB;

  // Image kinds
  localparam logic [1:0] KIND_BASIC  = 2'd0;
  localparam logic [1:0] KIND_BINARY = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;

  // Checksum status codes
  localparam logic [1:0] CSUM_MATCH    = 2'd0;
  localparam logic [1:0] CSUM_MISMATCH = 2'd1;
  localparam logic [1:0] CSUM_NONE     = 2'd2;

  // Result kinds
  localparam logic RK_WRITE   = 1'b0;
  localparam logic RK_SUMMARY = 1'b1;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_NAMED_HEADER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASIC_LOAD   = 1'b1;

  localparam logic        NAMED_HEADER_RST = 1'b1;
  localparam logic [15:0] BASIC_LOAD_RST   = 16'h694D;

  typedef struct packed {
    logic       start_frame;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [1:0]  image_kind;
    logic [15:0] last_address;
    logic [15:0] run_address;
    logic [1:0]  checksum_status;
    logic [15:0] jump_pc;
    logic [15:0] hl_value;
    logic [15:0] de_value;
    logic        de_written;
  } result_t;

endpackage

### rtl/core/tid_in_stage.sv
// Input register of the tape image deframer: holds one accepted byte.
// Depends on tid_pkg.
`timescale 1ns / 1ps

module tid_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tid_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              item_valid,
  output tid_pkg::in_item_t item
);
  import tid_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     in_fire;

  assign in_ready = !valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### rtl/core/tid_parse_core.sv
// Frame parser of the tape image deframer: phase state and per-byte result.
// Depends on tid_pkg and tape_image_deframer_assert.svh.
`timescale 1ns / 1ps
`include "tape_image_deframer_assert.svh"

module tid_parse_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              named_header,
  input  logic [15:0]       basic_load_address,
  input  logic              item_valid,
  input  tid_pkg::in_item_t item,
  input  logic              advance,
  output logic              res_valid,
  output tid_pkg::result_t  res
);
  import tid_pkg::*;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_MARK    = 4'd1,
    PH_HDR     = 4'd2,
    PH_PAYLOAD = 4'd3,
    PH_CSUM    = 4'd4,
    PH_SPARE   = 4'd5,
    PH_RUNLO   = 4'd6,
    PH_RUNHI   = 4'd7,
    PH_DONE    = 4'd8
  } phase_t;

  phase_t      phase_r, phase_cur, phase_nxt;
  logic [1:0]  quote_r, quote_cur, quote_nxt;
  logic [1:0]  kind_r, kind_cur, kind_nxt;
  logic [1:0]  hdr_idx_r, hdr_idx_cur, hdr_idx_nxt;
  logic [15:0] len_r, len_cur, len_nxt;
  logic [15:0] load_r, load_cur, load_nxt;
  logic [15:0] addr_r, addr_cur, addr_nxt;
  logic [15:0] left_r, left_cur, left_nxt;
  logic [7:0]  sum_r, sum_cur, sum_nxt;
  logic [1:0]  stat_r, stat_cur, stat_nxt;
  logic [7:0]  run_lo_r, run_lo_cur, run_lo_nxt;

  logic        step;
  logic [7:0]  b;
  logic        do_type;
  logic        do_begin;
  logic        do_summary;
  logic        sel_len;
  logic [15:0] run_val;
  logic [15:0] span;
  logic [15:0] end_addr;

  assign step = item_valid && advance;
  assign b    = item.data_byte;

  // A start byte drops the frame in progress before it is parsed
  always_comb begin
    if (item.start_frame) begin
      phase_cur   = PH_START;
      quote_cur   = 2'd0;
      kind_cur    = KIND_BASIC;
      hdr_idx_cur = 2'd0;
      len_cur     = 16'd0;
      load_cur    = 16'd0;
      addr_cur    = 16'd0;
      left_cur    = 16'd0;
      sum_cur     = 8'd0;
      stat_cur    = CSUM_NONE;
      run_lo_cur  = 8'd0;
    end else begin
      phase_cur   = phase_r;
      quote_cur   = quote_r;
      kind_cur    = kind_r;
      hdr_idx_cur = hdr_idx_r;
      len_cur     = len_r;
      load_cur    = load_r;
      addr_cur    = addr_r;
      left_cur    = left_r;
      sum_cur     = sum_r;
      stat_cur    = stat_r;
      run_lo_cur  = run_lo_r;
    end
  end

  assign span     = load_cur + len_cur;
  assign end_addr = span - 16'd1;

  always_comb begin
    phase_nxt   = phase_cur;
    quote_nxt   = quote_cur;
    kind_nxt    = kind_cur;
    hdr_idx_nxt = hdr_idx_cur;
    len_nxt     = len_cur;
    load_nxt    = load_cur;
    addr_nxt    = addr_cur;
    left_nxt    = left_cur;
    sum_nxt     = sum_cur;
    stat_nxt    = stat_cur;
    run_lo_nxt  = run_lo_cur;
    do_type     = 1'b0;
    do_begin    = 1'b0;
    do_summary  = 1'b0;
    sel_len     = 1'b0;
    run_val     = 16'd0;
    res_valid   = 1'b0;
    res         = '0;

    unique case (phase_cur)
      PH_START: begin
        if (named_header) begin
          if (b == QUOTE_BYTE) begin
            quote_nxt = quote_cur + 2'd1;
            // second quote ends the name
            if (quote_cur == 2'd1 || quote_cur == 2'd2) begin
              phase_nxt = PH_MARK;
            end
          end
        end else if (b != MARK_BYTE) begin
          do_type = 1'b1;
        end else begin
          phase_nxt = PH_MARK;
          quote_nxt = 2'd3;
        end
      end
      PH_MARK: begin
        // quote count of three flags the marker as already consumed
        if (b == MARK_BYTE && quote_cur != 2'd3) begin
          quote_nxt = 2'd3;
        end else begin
          do_type = 1'b1;
        end
      end
      PH_HDR: begin
        if (kind_cur == KIND_BASIC) begin
          if (hdr_idx_cur == 2'd0) begin
            len_nxt = {8'd0, b};
          end else begin
            len_nxt = {b, len_cur[7:0]};
          end
          hdr_idx_nxt = hdr_idx_cur + 2'd1;
          if (hdr_idx_cur == 2'd1) begin
            do_begin = 1'b1;
          end
        end else begin
          // binary: length then load; data: load then length
          sel_len = ((kind_cur == KIND_BINARY) == !hdr_idx_cur[1]);
          if (sel_len) begin
            len_nxt = hdr_idx_cur[0] ? {b, len_cur[7:0]} : {8'd0, b};
          end else begin
            load_nxt = hdr_idx_cur[0] ? {b, load_cur[7:0]} : {8'd0, b};
          end
          if (hdr_idx_cur == 2'd3) begin
            hdr_idx_nxt = 2'd0;
            do_begin    = 1'b1;
          end else begin
            hdr_idx_nxt = hdr_idx_cur + 2'd1;
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid         = 1'b1;
        res.result_kind   = RK_WRITE;
        res.write_address = addr_cur;
        res.write_data    = b;
        sum_nxt  = sum_cur + b;
        addr_nxt = addr_cur + 16'd1;
        left_nxt = left_cur - 16'd1;
        if (left_cur == 16'd1) begin
          phase_nxt = (kind_cur == KIND_BASIC) ? PH_RUNLO : PH_CSUM;
        end
      end
      PH_CSUM: begin
        stat_nxt  = (b == sum_cur) ? CSUM_MATCH : CSUM_MISMATCH;
        phase_nxt = PH_SPARE;
      end
      PH_SPARE: begin
        if (kind_cur == KIND_BINARY) begin
          phase_nxt = PH_RUNLO;
        end else begin
          do_summary = 1'b1;
        end
      end
      PH_RUNLO: begin
        run_lo_nxt = b;
        phase_nxt  = PH_RUNHI;
      end
      PH_RUNHI: begin
        do_summary = 1'b1;
        run_val    = {b, run_lo_cur};
      end
      PH_DONE: begin
        // drop bytes until the next start
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    if (do_type) begin
      if (b == TYPE_BASIC) begin
        kind_nxt = KIND_BASIC;
      end else if (b == TYPE_BINARY) begin
        kind_nxt = KIND_BINARY;
      end else begin
        kind_nxt = KIND_DATA;
      end
      hdr_idx_nxt = 2'd0;
      len_nxt     = 16'd0;
      load_nxt    = (kind_nxt == KIND_BASIC) ? basic_load_address : 16'd0;
      sum_nxt     = 8'd0;
      stat_nxt    = (kind_nxt == KIND_BASIC) ? CSUM_NONE : CSUM_MATCH;
      phase_nxt   = PH_HDR;
    end

    if (do_begin) begin
      addr_nxt = load_nxt;
      left_nxt = len_nxt;
      if (len_nxt != 16'd0) begin
        phase_nxt = PH_PAYLOAD;
      end else begin
        phase_nxt = (kind_cur == KIND_BASIC) ? PH_RUNLO : PH_CSUM;
      end
    end

    if (do_summary) begin
      res_valid           = 1'b1;
      res.result_kind     = RK_SUMMARY;
      res.image_kind      = kind_cur;
      res.last_address    = end_addr;
      res.run_address     = run_val;
      res.checksum_status = stat_cur;
      if (run_val != 16'd0 && kind_cur == KIND_BINARY) begin
        res.jump_pc    = run_val;
        res.hl_value   = run_val;
        res.de_written = 1'b0;
      end else if (run_val != 16'd0 && kind_cur == KIND_BASIC) begin
        res.jump_pc    = PC_BASIC;
        res.hl_value   = end_addr;
        res.de_value   = run_val;
        res.de_written = 1'b1;
      end else begin
        res.jump_pc    = PC_PROMPT;
        res.hl_value   = end_addr;
        res.de_value   = run_val;
        res.de_written = 1'b1;
      end
      phase_nxt = PH_DONE;
    end

    res_valid = res_valid && item_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      quote_r   <= 2'd0;
      kind_r    <= KIND_BASIC;
      hdr_idx_r <= 2'd0;
      len_r     <= 16'd0;
      load_r    <= 16'd0;
      addr_r    <= 16'd0;
      left_r    <= 16'd0;
      sum_r     <= 8'd0;
      stat_r    <= CSUM_NONE;
      run_lo_r  <= 8'd0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      quote_r   <= quote_nxt;
      kind_r    <= kind_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      len_r     <= len_nxt;
      load_r    <= load_nxt;
      addr_r    <= addr_nxt;
      left_r    <= left_nxt;
      sum_r     <= sum_nxt;
      stat_r    <= stat_nxt;
      run_lo_r  <= run_lo_nxt;
    end
  end

  `TID_ASSERT_NOW(a_write_in_payload, clk, rst_n,
    res_valid && res.result_kind == RK_WRITE, phase_r == PH_PAYLOAD && !item.start_frame,
    "memory write produced outside the payload phase")
  `TID_ASSERT_NOW(a_payload_count, clk, rst_n,
    phase_r == PH_PAYLOAD, left_r != 16'd0,
    "payload phase with no bytes left")
  `TID_ASSERT_NEXT(a_summary_done, clk, rst_n,
    step && res_valid && res.result_kind == RK_SUMMARY, phase_r == PH_DONE,
    "frame summary did not close the frame")

endmodule

### rtl/core/tid_out_stage.sv
// Result register of the tape image deframer: holds one result for the receiver.
// Depends on tid_pkg.
`timescale 1ns / 1ps

module tid_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  tid_pkg::result_t res,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_ready,
  output tid_pkg::result_t out_res
);
  import tid_pkg::*;

  logic    valid_r;
  result_t res_r;

  // Register is free when empty or being drained this cycle
  assign advance = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### rtl/core/tape_image_deframer.sv
// Tape image deframer, top level.
// Channels: in_* carries one raw image byte per transaction (valid/ready),
//   in_start_frame marks the first byte of a new image and drops any frame
//   in progress. out_* carries at most one result per byte: a memory write
//   for each payload byte, then one frame summary with the end address,
//   checksum status and register values for the jump.
// Configuration: cfg_write_en writes cfg_write_data to register cfg_index
//   (0 named_header, 1 basic_load_address) at the clock edge; write only
//   while the block is idle.
// Path: each byte goes through the input register, the parse step, then the
//   result register, which drives out_valid.
// Throughput: one byte per cycle while out_ready does not stall, set by the
//   single parse step between the input register and the result register.
// Stall: while out_ready is low and a result is held, the parser and input
//   register hold; in_ready drops once the input register is also full.
// Reset (synchronous, rst_n low): both registers empty, parser back to the
//   name/marker phase, named_header = 1, basic_load_address = 0x694D.
// Depends on tid_pkg, tid_in_stage, tid_parse_core, tid_out_stage.
`timescale 1ns / 1ps

module tape_image_deframer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_start_frame,
  input  logic [7:0]                       in_data_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_result_kind,
  output logic [15:0]                      out_write_address,
  output logic [7:0]                       out_write_data,
  output logic [1:0]                       out_image_kind,
  output logic [15:0]                      out_last_address,
  output logic [15:0]                      out_run_address,
  output logic [1:0]                       out_checksum_status,
  output logic [15:0]                      out_jump_pc,
  output logic [15:0]                      out_hl_value,
  output logic [15:0]                      out_de_value,
  output logic                             out_de_written,
  input  logic                             cfg_write_en,
  input  logic [tid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tid_pkg::CFG_DATA_W-1:0]   cfg_write_data
);
  import tid_pkg::*;

  logic        named_header_r;
  logic [15:0] basic_load_r;

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     advance;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      named_header_r <= NAMED_HEADER_RST;
      basic_load_r   <= BASIC_LOAD_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_NAMED_HEADER: named_header_r <= cfg_write_data[0];
        CFG_BASIC_LOAD:   basic_load_r   <= cfg_write_data[15:0];
      endcase
    end
  end

  assign in_item.start_frame = in_start_frame;
  assign in_item.data_byte   = in_data_byte;

  tid_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  tid_parse_core u_parse_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .named_header       (named_header_r),
    .basic_load_address (basic_load_r),
    .item_valid         (item_valid),
    .item               (item),
    .advance            (advance),
    .res_valid          (res_valid),
    .res                (res)
  );

  tid_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_result_kind     = out_res.result_kind;
  assign out_write_address   = out_res.write_address;
  assign out_write_data      = out_res.write_data;
  assign out_image_kind      = out_res.image_kind;
  assign out_last_address    = out_res.last_address;
  assign out_run_address     = out_res.run_address;
  assign out_checksum_status = out_res.checksum_status;
  assign out_jump_pc         = out_res.jump_pc;
  assign out_hl_value        = out_res.hl_value;
  assign out_de_value        = out_res.de_value;
  assign out_de_written      = out_res.de_written;

endmodule

### tb/sv/tape_image_deframer_chk.sv
// Result checker for the tape image deframer: watches the byte, result and
// register ports, predicts each memory write and frame summary, compares.
// Depends on tid_pkg.
`timescale 1ns / 1ps

module tape_image_deframer_chk (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_start_frame,
  input  logic [7:0]                     in_data_byte,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_result_kind,
  input  logic [15:0]                    out_write_address,
  input  logic [7:0]                     out_write_data,
  input  logic [1:0]                     out_image_kind,
  input  logic [15:0]                    out_last_address,
  input  logic [15:0]                    out_run_address,
  input  logic [1:0]                     out_checksum_status,
  input  logic [15:0]                    out_jump_pc,
  input  logic [15:0]                    out_hl_value,
  input  logic [15:0]                    out_de_value,
  input  logic                           out_de_written,
  input  logic                           cfg_write_en,
  input  logic [tid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tid_pkg::CFG_DATA_W-1:0] cfg_write_data,
  output int                             mismatches,
  output int                             results_due
);
  import tid_pkg::*;

  typedef enum logic [3:0] {
    ST_START, ST_MARK, ST_HDR, ST_PAYLOAD, ST_CSUM, ST_SPARE, ST_RUNLO, ST_RUNHI, ST_DONE
  } parse_state_t;

  // register copies
  logic        named_cfg;
  logic [15:0] basic_load_cfg;

  // parser copy
  parse_state_t state;
  logic [1:0]   quote_cnt;
  logic [1:0]   kind;
  logic [1:0]   hdr_idx;
  logic [15:0]  length;
  logic [15:0]  load_addr;
  logic [15:0]  wr_addr;
  logic [15:0]  remaining;
  logic [7:0]   sum;
  logic [1:0]   csum_stat;
  logic [7:0]   run_lo;

  result_t due_results[$];

  initial mismatches = 0;
  initial results_due = 0;

  task automatic clear_parse();
    state     = ST_START;
    quote_cnt = '0;
    kind      = '0;
    hdr_idx   = '0;
    length    = '0;
    load_addr = '0;
    wr_addr   = '0;
    remaining = '0;
    sum       = '0;
    csum_stat = CSUM_NONE;
    run_lo    = '0;
  endtask

  task automatic finish_payload();
    state = (kind == KIND_BASIC) ? ST_RUNLO : ST_CSUM;
  endtask

  task automatic start_payload();
    wr_addr   = load_addr;
    remaining = length;
    if (remaining == 0) finish_payload();
    else state = ST_PAYLOAD;
  endtask

  task automatic take_type_byte(input logic [7:0] b);
    if (b == TYPE_BASIC) kind = KIND_BASIC;
    else if (b == TYPE_BINARY) kind = KIND_BINARY;
    else kind = KIND_DATA;
    hdr_idx   = '0;
    length    = '0;
    load_addr = (kind == KIND_BASIC) ? basic_load_cfg : 16'h0000;
    sum       = '0;
    csum_stat = (kind == KIND_BASIC) ? CSUM_NONE : CSUM_MATCH;
    state     = ST_HDR;
  endtask

  task automatic push_summary(input logic [15:0] run);
    result_t     r;
    logic [15:0] last;
    last = load_addr + length - 16'd1;
    r = '0;
    r.result_kind     = RK_SUMMARY;
    r.image_kind      = kind;
    r.last_address    = last;
    r.run_address     = run;
    r.checksum_status = csum_stat;
    r.de_written      = 1'b1;
    if (run != 0 && kind == KIND_BINARY) begin
      // binary with a run address jumps straight there, DE untouched
      r.jump_pc    = run;
      r.hl_value   = run;
      r.de_written = 1'b0;
    end else begin
      r.jump_pc  = (run != 0 && kind == KIND_BASIC) ? PC_BASIC : PC_PROMPT;
      r.hl_value = last;
      r.de_value = run;
    end
    due_results.push_back(r);
    state = ST_DONE;
  endtask

  task automatic deframe_byte(input logic start, input logic [7:0] b);
    result_t r;
    if (start) clear_parse();
    case (state)
      ST_START: begin
        if (named_cfg) begin
          if (b == QUOTE_BYTE) begin
            quote_cnt = quote_cnt + 2'd1;
            if (quote_cnt >= 2) state = ST_MARK;
          end
        end else if (b == MARK_BYTE) begin
          // marker already consumed: the next byte is the type
          state     = ST_MARK;
          quote_cnt = 2'd3;
        end else begin
          take_type_byte(b);
        end
      end
      ST_MARK: begin
        if (b == MARK_BYTE && quote_cnt != 2'd3) quote_cnt = 2'd3;
        else take_type_byte(b);
      end
      ST_HDR: begin
        if (kind == KIND_BASIC) begin
          if (hdr_idx == 0) length = {8'h00, b};
          else length = length | {b, 8'h00};
          hdr_idx = hdr_idx + 2'd1;
          if (hdr_idx == 2) start_payload();
        end else begin
          // binary: length then load; data: load then length
          if ((kind == KIND_BINARY) == (hdr_idx < 2)) begin
            if (!hdr_idx[0]) length = {8'h00, b};
            else length = length | {b, 8'h00};
          end else begin
            if (!hdr_idx[0]) load_addr = {8'h00, b};
            else load_addr = load_addr | {b, 8'h00};
          end
          if (hdr_idx == 2'd3) begin
            hdr_idx = '0;
            start_payload();
          end else begin
            hdr_idx = hdr_idx + 2'd1;
          end
        end
      end
      ST_PAYLOAD: begin
        r = '0;
        r.result_kind   = RK_WRITE;
        r.write_address = wr_addr;
        r.write_data    = b;
        due_results.push_back(r);
        sum       = sum + b;
        wr_addr   = wr_addr + 16'd1;
        remaining = remaining - 16'd1;
        if (remaining == 0) finish_payload();
      end
      ST_CSUM: begin
        csum_stat = (b == sum) ? CSUM_MATCH : CSUM_MISMATCH;
        state     = ST_SPARE;
      end
      ST_SPARE: begin
        if (kind == KIND_BINARY) state = ST_RUNLO;
        else push_summary(16'h0000);
      end
      ST_RUNLO: begin
        run_lo = b;
        state  = ST_RUNHI;
      end
      ST_RUNHI: push_summary({b, run_lo});
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_result();
    result_t want;
    if (due_results.size() == 0) begin
      $error("out_result_kind: expected no transaction, actual %0d", out_result_kind);
      mismatches++;
    end else begin
      want = due_results.pop_front();
      check_field("out_result_kind", 16'(want.result_kind), 16'(out_result_kind));
      check_field("out_write_address", want.write_address, out_write_address);
      check_field("out_write_data", 16'(want.write_data), 16'(out_write_data));
      check_field("out_image_kind", 16'(want.image_kind), 16'(out_image_kind));
      check_field("out_last_address", want.last_address, out_last_address);
      check_field("out_run_address", want.run_address, out_run_address);
      check_field("out_checksum_status", 16'(want.checksum_status),
                  16'(out_checksum_status));
      check_field("out_jump_pc", want.jump_pc, out_jump_pc);
      check_field("out_hl_value", want.hl_value, out_hl_value);
      check_field("out_de_value", want.de_value, out_de_value);
      check_field("out_de_written", 16'(want.de_written), 16'(out_de_written));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      named_cfg      = NAMED_HEADER_RST;
      basic_load_cfg = BASIC_LOAD_RST;
      clear_parse();
      due_results.delete();
    end else begin
      // retire results before queuing new ones from this edge
      if (out_valid && out_ready) compare_result();
      if (in_valid && in_ready) deframe_byte(in_start_frame, in_data_byte);
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_NAMED_HEADER: named_cfg = cfg_write_data[0];
          CFG_BASIC_LOAD:   basic_load_cfg = cfg_write_data;
          default: ;
        endcase
      end
    end
    results_due = due_results.size();
  end

endmodule

### tb/sv/tape_image_deframer_tb.sv
// Testbench top for the tape image deframer: clock, reset, register writes,
// byte stimulus with random gaps and result back-pressure, final verdict.
// Depends on tid_pkg, tape_image_deframer and tape_image_deframer_chk.
`timescale 1ns / 1ps

module tape_image_deframer_tb;
  import tid_pkg::*;

  localparam int ITEM_TARGET  = 2000;
  localparam int PHASES       = 6;
  localparam int DRAIN_CYCLES = 6;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_start_frame = 1'b0;
  logic [7:0]            in_data_byte = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic                  out_result_kind;
  logic [15:0]           out_write_address;
  logic [7:0]            out_write_data;
  logic [1:0]            out_image_kind;
  logic [15:0]           out_last_address;
  logic [15:0]           out_run_address;
  logic [1:0]            out_checksum_status;
  logic [15:0]           out_jump_pc;
  logic [15:0]           out_hl_value;
  logic [15:0]           out_de_value;
  logic                  out_de_written;
  logic                  cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_write_data = '0;
  int                    mismatches;
  int                    results_due;

  logic [7:0]  image_bytes[$];
  int          body_len;
  int          bytes_sent = 0;
  int          steady_left = 0;
  int          stall_left = 0;
  int unsigned ready_draw;
  logic        named_now = NAMED_HEADER_RST;

  tape_image_deframer dut (.*);

  tape_image_deframer_chk result_chk (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // result side: open stretches, short stalls, the odd long stall
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      ready_draw = $urandom_range(0, 99);
      if (ready_draw < 50) begin
        out_ready  <= 1'b1;
        stall_left <= $urandom_range(0, 30);
      end else if (ready_draw < 90) begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_ready  <= 1'b0;
        stall_left <= $urandom_range(5, 40);
      end
    end
  end

  task automatic send_byte(input logic start, input logic [7:0] value);
    int unsigned gap;
    int unsigned draw;
    if (steady_left != 0) begin
      steady_left--;
      gap = 0;
    end else begin
      draw = $urandom_range(0, 99);
      if (draw < 3) begin
        steady_left = $urandom_range(20, 80);
        gap = 0;
      end else if (draw < 68) gap = 0;
      else if (draw < 94) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_start_frame <= start;
    in_data_byte   <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  // send the first count bytes of the image, start_frame on the first
  task automatic send_image(input int count);
    for (int i = 0; i < count; i++) begin
      send_byte(i == 0, image_bytes[i]);
      if (i < body_len) bytes_sent++;
    end
  endtask

  // drop valid, wait for every result, then let the parser drain
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    settle();
    cfg_write_en   <= 1'b1;
    cfg_index      <= idx;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (idx == CFG_NAMED_HEADER) named_now = value[0];
  endtask

  function automatic logic [7:0] non_quote();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == QUOTE_BYTE);
    return b;
  endfunction

  // mostly short payloads, a few that need a nonzero length high byte
  function automatic int unsigned draw_length();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 10) return 0;
    if (p < 70) return $urandom_range(1, 16);
    if (p < 90) return $urandom_range(17, 64);
    if (p < 98) return $urandom_range(65, 255);
    return $urandom_range(256, 700);
  endfunction

  task automatic build_image();
    int unsigned len;
    int unsigned pick;
    logic [7:0]  type_code;
    logic [7:0]  value;
    logic [7:0]  sum;
    logic [15:0] load;
    logic [15:0] run;
    logic        marker;
    image_bytes.delete();
    if (named_now) begin
      repeat ($urandom_range(0, 2)) image_bytes.push_back(non_quote());
      image_bytes.push_back(QUOTE_BYTE);
      repeat ($urandom_range(0, 6)) image_bytes.push_back(non_quote());
      image_bytes.push_back(QUOTE_BYTE);
    end
    marker = ($urandom_range(0, 1) == 1);
    if (marker) image_bytes.push_back(MARK_BYTE);
    pick = $urandom_range(0, 2);
    if (pick == 0) type_code = TYPE_BASIC;
    else if (pick == 1) type_code = TYPE_BINARY;
    else begin
      // any other code is data; a second marker byte counts as data too
      do type_code = 8'($urandom_range(0, 255));
      while (type_code == TYPE_BASIC || type_code == TYPE_BINARY ||
             (!marker && type_code == MARK_BYTE));
    end
    image_bytes.push_back(type_code);
    len  = draw_length();
    load = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(16'hFFF0, 16'hFFFF))
                                       : 16'($urandom_range(0, 65535));
    if (pick == 0) begin
      image_bytes.push_back(8'(len));
      image_bytes.push_back(8'(len >> 8));
    end else if (pick == 1) begin
      image_bytes.push_back(8'(len));
      image_bytes.push_back(8'(len >> 8));
      image_bytes.push_back(load[7:0]);
      image_bytes.push_back(load[15:8]);
    end else begin
      image_bytes.push_back(load[7:0]);
      image_bytes.push_back(load[15:8]);
      image_bytes.push_back(8'(len));
      image_bytes.push_back(8'(len >> 8));
    end
    sum = 8'h00;
    repeat (len) begin
      value = 8'($urandom_range(0, 255));
      sum   = sum + value;
      image_bytes.push_back(value);
    end
    if (pick != 0) begin
      if ($urandom_range(0, 4) == 0) image_bytes.push_back(sum ^ 8'($urandom_range(1, 255)));
      else image_bytes.push_back(sum);
      image_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if (pick != 2) begin
      run = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom_range(0, 65535));
      image_bytes.push_back(run[7:0]);
      image_bytes.push_back(run[15:8]);
    end
    body_len = image_bytes.size();
    // trailing bytes after a finished frame are dropped by the block
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) image_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned pick;
    logic [15:0] load_setting;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // named basic, one byte, nonzero run address
    image_bytes = '{8'h22, 8'h22, 8'h42, 8'h01, 8'h00, 8'hFF, 8'h34, 8'h12};
    body_len = image_bytes.size();
    send_image(body_len);
    write_reg(CFG_NAMED_HEADER, 16'h0000);
    // binary after marker: zero length, load at 0xFFFF, run address taken as jump
    image_bytes = '{8'hA5, 8'h4D, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80};
    body_len = image_bytes.size();
    send_image(body_len);
    // second marker byte is a data type; writes wrap past 0xFFFF, bad checksum
    image_bytes = '{8'hA5, 8'hA5, 8'hFF, 8'hFF, 8'h02, 8'h00, 8'h80, 8'h7F, 8'h00, 8'h00};
    body_len = image_bytes.size();
    send_image(body_len);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_setting = 16'h0000;
        1: load_setting = 16'hFFFF;
        4: load_setting = BASIC_LOAD_RST;
        5: load_setting = 16'hFFF8;
        default: load_setting = 16'($urandom_range(0, 65535));
      endcase
      write_reg(CFG_NAMED_HEADER, {15'd0, ph[0] == 1'b0});
      write_reg(CFG_BASIC_LOAD, load_setting);
      while (bytes_sent < (ph + 1) * ITEM_TARGET / PHASES) begin
        pick = $urandom_range(0, 99);
        build_image();
        if (pick < 80) begin
          send_image(image_bytes.size());
        end else if (pick < 92) begin
          // cut the frame short; the next one restarts with start_frame
          send_image($urandom_range(1, image_bytes.size()));
        end else begin
          repeat ($urandom_range(1, 8)) begin
            send_byte($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
            bytes_sent++;
          end
        end
      end
    end

    settle();
    @(negedge clk);
    if (mismatches == 0) begin
      $display("tape_image_deframer_tb passed");
    end else begin
      $display("tape_image_deframer_tb failed");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("tape_image_deframer_tb failed");
    $finish;
  end

endmodule
